// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is high
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   `ASSERT_PROP(label, clk, rst, (pre) |=> (post), msg)

`endif

// ----- src/hcap_pkg.sv -----
// ---------------------------------------------------------------------------
// hcap_pkg
// types, codes and character constants of the hex address parser
// ---------------------------------------------------------------------------
package hcap_pkg;

   // default address length limit in bytes
   localparam int MaxAddrBytesDefault = 8;

   // result event codes
   localparam logic [2:0] EvConsumed = 3'd0;
   localparam logic [2:0] EvByte     = 3'd1;
   localparam logic [2:0] EvSuccess  = 3'd2;
   localparam logic [2:0] EvError    = 3'd3;
   localparam logic [2:0] EvIgnored  = 3'd4;

   // characters of interest
   localparam logic [7:0] CharNul     = 8'h00;
   localparam logic [7:0] CharTab     = 8'h09;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharColon   = 8'h3a;
   localparam logic [7:0] CharDigit0  = 8'h30;
   localparam logic [7:0] CharDigit9  = 8'h39;
   localparam logic [7:0] CharLowerA  = 8'h61;
   localparam logic [7:0] CharLowerF  = 8'h66;
   localparam logic [7:0] CharUpperA  = 8'h41;
   localparam logic [7:0] CharUpperF  = 8'h46;
   localparam logic [7:0] LetterValue = 8'd10;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_LOW    = 5'b00010,
      PH_AFTER  = 5'b00100,
      PH_NEXT   = 5'b01000,
      PH_FAILED = 5'b10000
   } phase_type;

   // classification of one input character
   typedef struct packed {
      logic       is_blank;
      logic       is_hex;
      logic       is_colon;
      logic       is_nul;
      logic [3:0] nibble;
   } char_class_type;

endpackage

// ----- src/hcap_char_decode.sv -----
// ---------------------------------------------------------------------------
// hcap_char_decode
// classifies one character and converts a hex digit to its nibble value
// ---------------------------------------------------------------------------
module hcap_char_decode (
   input  logic [7:0]                character,
   output hcap_pkg::char_class_type  char_class
);
   import hcap_pkg::*;

   logic is_digit;
   logic is_lower;
   logic is_upper;
   logic [7:0] lower_value;
   logic [7:0] upper_value;
   logic [7:0] digit_value;

   // range checks
   assign is_digit = (character >= CharDigit0) && (character <= CharDigit9);
   assign is_lower = (character >= CharLowerA) && (character <= CharLowerF);
   assign is_upper = (character >= CharUpperA) && (character <= CharUpperF);

   // digit values
   assign digit_value = character - CharDigit0;
   assign lower_value = character - CharLowerA + LetterValue;
   assign upper_value = character - CharUpperA + LetterValue;

   // class flags and nibble
   always_comb begin
      char_class.is_blank = (character == CharSpace) || (character == CharTab);
      char_class.is_hex   = is_digit || is_lower || is_upper;
      char_class.is_colon = (character == CharColon);
      char_class.is_nul   = (character == CharNul);
      if (is_digit) begin
         char_class.nibble = digit_value[3:0];
      end else if (is_lower) begin
         char_class.nibble = lower_value[3:0];
      end else if (is_upper) begin
         char_class.nibble = upper_value[3:0];
      end else begin
         char_class.nibble = 4'd0;
      end
   end

endmodule

// ----- src/hex_colon_address_parser_top.sv -----
// ---------------------------------------------------------------------------
// hex_colon_address_parser_top
// parses a colon-separated hex address one character per word
// ---------------------------------------------------------------------------
// Takes one character per word and returns exactly one result word for it
// in the next cycle, through a result register. A new character is taken in
// each cycle unless stalled: the phase, first nibble and byte count registers
// are updated in the same cycle it is accepted, so throughput is one word per
// cycle. req_stall is high only while a result is held and rsp_stall is high.
// Events: consumed, byte completed (with value and index), success at NUL
// (with length), error, and ignored until the NUL that re-arms the parser.
// MAX_ADDR_BYTES (1 to 64) sets the longest address accepted.
module hex_colon_address_parser_top #(
   parameter int MAX_ADDR_BYTES = hcap_pkg::MaxAddrBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_byte_value,
   output logic [5:0] rsp_byte_index,
   output logic [6:0] rsp_address_length
);
   import hcap_pkg::*;

   localparam logic [6:0] MaxCount = 7'(MAX_ADDR_BYTES);

   char_class_type char_class;

   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [6:0] byte_count_ff, byte_count_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] event_ff, event_in;
   logic [7:0] value_ff, value_in;
   logic [5:0] index_ff, index_in;
   logic [6:0] length_ff, length_in;

   logic accept;
   logic rearm;

   hcap_char_decode u_decode (
      .character  (req_character),
      .char_class (char_class)
   );

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // phase update and result for the current character
   always_comb begin
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      byte_count_in  = byte_count_ff;
      event_in       = EvConsumed;
      value_in       = 8'd0;
      index_in       = 6'd0;
      rearm          = 1'b0;

      unique case (phase_ff)
         PH_START: begin
            if (char_class.is_blank) begin
               event_in = EvConsumed;
            end else if (char_class.is_hex) begin
               high_nibble_in = char_class.nibble;
               phase_in       = PH_LOW;
            end else begin
               event_in = EvError;
            end
         end
         PH_NEXT: begin
            if (char_class.is_hex) begin
               high_nibble_in = char_class.nibble;
               phase_in       = PH_LOW;
            end else begin
               event_in = EvError;
            end
         end
         PH_LOW: begin
            if (char_class.is_hex) begin
               value_in      = {high_nibble_ff, char_class.nibble};
               index_in      = byte_count_ff[5:0];
               byte_count_in = byte_count_ff + 7'd1;
               event_in      = EvByte;
               phase_in      = PH_AFTER;
            end else begin
               event_in = EvError;
            end
         end
         PH_AFTER: begin
            if (char_class.is_blank) begin
               event_in = EvConsumed;
            end else if (char_class.is_colon) begin
               if (byte_count_ff >= MaxCount) begin
                  event_in = EvError;
               end else begin
                  phase_in = PH_NEXT;
               end
            end else if (char_class.is_nul) begin
               event_in = EvSuccess;
               rearm    = 1'b1;
            end else begin
               event_in = EvError;
            end
         end
         PH_FAILED: begin
            event_in = EvIgnored;
            rearm    = char_class.is_nul;
         end
         default: begin
            event_in = EvIgnored;
            phase_in = PH_FAILED;
         end
      endcase

      // error handling: NUL re-arms at once, anything else starts ignoring
      if (event_in == EvError) begin
         if (char_class.is_nul) begin
            rearm = 1'b1;
         end else begin
            phase_in = PH_FAILED;
         end
      end

      length_in = byte_count_in;

      if (rearm) begin
         phase_in       = PH_START;
         high_nibble_in = 4'd0;
         byte_count_in  = 7'd0;
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         high_nibble_ff <= 4'd0;
         byte_count_ff  <= 7'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff       <= phase_in;
            high_nibble_ff <= high_nibble_in;
            byte_count_ff  <= byte_count_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= event_in;
         value_ff  <= value_in;
         index_ff  <= index_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = event_ff;
   assign rsp_byte_value     = value_ff;
   assign rsp_byte_index     = index_ff;
   assign rsp_address_length = length_ff;

endmodule

// ----- src/hcap_checker.sv -----
// ---------------------------------------------------------------------------
// hcap_checker
// port-level assertions for the hex address parser, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hcap_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_character,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_byte_value,
   input logic [5:0] rsp_byte_index,
   input logic [6:0] rsp_address_length
);
   import hcap_pkg::*;

   logic unused_character;
   assign unused_character = ^req_character;

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")

   // every accepted character yields a result in the next cycle
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid, "result missing")

   // a completed byte is counted in the reported length
   `ASSERT_PROP(a_byte_len, clock, reset, (rsp_valid && rsp_event_res == EvByte) |-> (rsp_address_length == 7'(rsp_byte_index) + 7'd1), "length does not match byte index")

   // value and index are zero on any other event
   `ASSERT_PROP(a_idle_payload, clock, reset, (rsp_valid && rsp_event_res != EvByte) |-> (rsp_byte_value == 8'd0 && rsp_byte_index == 6'd0), "stray byte payload")

endmodule

bind hex_colon_address_parser_top hcap_checker u_hcap_checker (.*);
